// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the entity decoder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HEU_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("heu assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define HEU_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("heu assertion failed");

`endif

// ===== src/heu_pkg.sv =====
// ----------------------------------------------------------------------------
// heu_pkg
// Types, entity tables and helpers for the HTML entity decoder.
// ----------------------------------------------------------------------------
package heu_pkg;

	localparam int ENTITY_COUNT = 5;
	localparam int TABLE_SIZE   = 5;
	localparam int HOLD_DEPTH   = 5;
	localparam int MAX_ENT_LEN  = 6;
	localparam int ACTIVE_ENT   = (ENTITY_COUNT > TABLE_SIZE) ? TABLE_SIZE : ENTITY_COUNT;

	localparam int KW = 3; // entity index width
	localparam int CW = 3; // hold count / position width

	// & a m p ;   & l t ;   & g t ;   & q u o t ;   & # 3 9 ;
	localparam logic [7:0] ENT_TEXT [TABLE_SIZE][MAX_ENT_LEN] = '{
		'{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
		'{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
		'{8'h26, 8'h23, 8'h33, 8'h39, 8'h3B, 8'h00}
	};
	localparam logic [CW-1:0] ENT_LEN [TABLE_SIZE] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd5};
	// & < > " '
	localparam logic [7:0] ENT_CHAR [TABLE_SIZE] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_SCAN,
		S_RELEASE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic       vld;
		logic [7:0] data;
		logic       last;
	} emit_t;

	typedef struct packed {
		logic [KW-1:0] k;
		logic [CW-1:0] pos;
		logic [7:0]    ch;
	} match_req_t;

	typedef struct packed {
		logic       hit;
		logic       done;
		logic [7:0] rep;
	} match_rsp_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A)
			r = c + 8'd32;
		return r;
	endfunction

endpackage

// ===== src/heu_in_if.sv =====
// ----------------------------------------------------------------------------
// heu_in_if
// Escaped text channel: one byte per request with an end-of-string flag.
// ----------------------------------------------------------------------------
interface heu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_string;

	modport source (output valid, output text_byte, output end_of_string, input ready);
	modport sink (input valid, input text_byte, input end_of_string, output ready);
endinterface

// ===== src/heu_out_if.sv =====
// ----------------------------------------------------------------------------
// heu_out_if
// Decoded text channel: one byte per request with a last flag.
// ----------------------------------------------------------------------------
interface heu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== src/heu_match.sv =====
// ----------------------------------------------------------------------------
// heu_match
// Shared compare unit: checks one folded byte against one entity position.
// ----------------------------------------------------------------------------
module heu_match (
	input  heu_pkg::match_req_t req,
	output heu_pkg::match_rsp_t rsp
);

	logic [7:0]            lb;
	logic                  k_ok;
	logic [7:0]            ref_ch;
	logic [heu_pkg::CW-1:0] len;

	always_comb begin
		lb     = heu_pkg::fold_case(req.ch);
		k_ok   = (int'(req.k) < heu_pkg::ACTIVE_ENT);
		ref_ch = 8'h00;
		len    = '0;
		rsp    = '0;
		if (k_ok) begin
			len     = heu_pkg::ENT_LEN[req.k];
			rsp.rep = heu_pkg::ENT_CHAR[req.k];
			if (req.pos < len && int'(req.pos) < heu_pkg::MAX_ENT_LEN) begin
				ref_ch   = heu_pkg::ENT_TEXT[req.k][req.pos];
				rsp.hit  = (ref_ch == lb);
				rsp.done = ((4'(req.pos) + 4'd1) == 4'(len));
			end
		end
	end

endmodule

// ===== src/heu_ctrl.sv =====
// ----------------------------------------------------------------------------
// heu_ctrl
// Sequencer: holds candidate bytes, drives the compare unit, releases bytes.
// ----------------------------------------------------------------------------
module heu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  heu_pkg::in_item_t item,
	output logic              idle,
	input  logic              take,
	output heu_pkg::emit_t    emit
);

	heu_pkg::state_t         state_q, state_d;
	logic [7:0]              byte_q;
	logic                    eos_q;
	logic [heu_pkg::CW-1:0]  cnt_q, cnt_d;
	logic [heu_pkg::KW-1:0]  cand_q, cand_d;
	logic [heu_pkg::KW-1:0]  k_q, k_d;
	logic [heu_pkg::CW-1:0]  rd_q, rd_d;
	logic                    fin_q, fin_d;
	logic [7:0]              emit_q, emit_d;
	logic [7:0]              pend_q [heu_pkg::HOLD_DEPTH];
	logic                    pend_we;
	logic                    do_hold;
	logic                    rd_last;

	heu_pkg::match_req_t req;
	heu_pkg::match_rsp_t rsp;

	heu_match u_match (
		.req (req),
		.rsp (rsp)
	);

	assign idle    = (state_q == heu_pkg::S_IDLE);
	assign rd_last = (rd_q == heu_pkg::CW'(cnt_q - 3'd1));

	always_comb begin
		req.ch  = byte_q;
		req.pos = cnt_q;
		if (state_q == heu_pkg::S_SCAN)
			req.k = k_q;
		else if (cnt_q == '0)
			req.k = '0;
		else
			req.k = cand_q;
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cand_d    = cand_q;
		k_d       = k_q;
		rd_d      = rd_q;
		fin_d     = fin_q;
		emit_d    = emit_q;
		pend_we   = 1'b0;
		do_hold   = 1'b0;
		emit.vld  = 1'b0;
		emit.data = emit_q;
		emit.last = eos_q;
		unique case (state_q)
			heu_pkg::S_IDLE: begin
				if (acc)
					state_d = heu_pkg::S_EVAL;
			end
			heu_pkg::S_EVAL: begin
				if (cnt_q == '0) begin
					if (rsp.hit) begin
						do_hold = 1'b1;
					end else begin
						emit.vld  = 1'b1;
						emit.data = byte_q;
						emit_d    = byte_q;
						state_d   = take ? heu_pkg::S_IDLE : heu_pkg::S_EMIT;
					end
				end else if (cnt_q == 3'd1) begin
					k_d     = '0;
					state_d = heu_pkg::S_SCAN;
				end else if (rsp.hit && rsp.done) begin
					cnt_d     = '0;
					cand_d    = '0;
					emit.vld  = 1'b1;
					emit.data = rsp.rep;
					emit_d    = rsp.rep;
					state_d   = take ? heu_pkg::S_IDLE : heu_pkg::S_EMIT;
				end else if (rsp.hit) begin
					do_hold = 1'b1;
				end else begin
					rd_d    = '0;
					fin_d   = 1'b0;
					state_d = heu_pkg::S_RELEASE;
				end
			end
			heu_pkg::S_SCAN: begin
				// one table entry per cycle against the second byte
				if (rsp.hit) begin
					cand_d  = k_q;
					do_hold = 1'b1;
				end else if (int'(k_q) >= heu_pkg::ACTIVE_ENT - 1) begin
					rd_d    = '0;
					fin_d   = 1'b0;
					state_d = heu_pkg::S_RELEASE;
				end else begin
					k_d = heu_pkg::KW'(k_q + 3'd1);
				end
			end
			heu_pkg::S_RELEASE: begin
				emit.vld  = 1'b1;
				emit.data = pend_q[rd_q];
				emit.last = fin_q && rd_last;
				if (take) begin
					rd_d = heu_pkg::CW'(rd_q + 3'd1);
					if (rd_last) begin
						cnt_d  = '0;
						cand_d = '0;
						// after a mismatch, handle the new byte afresh
						state_d = fin_q ? heu_pkg::S_IDLE : heu_pkg::S_EVAL;
					end
				end
			end
			heu_pkg::S_EMIT: begin
				emit.vld = 1'b1;
				if (take)
					state_d = heu_pkg::S_IDLE;
			end
			default: state_d = heu_pkg::S_IDLE;
		endcase

		if (do_hold) begin
			if (int'(cnt_q) < heu_pkg::HOLD_DEPTH) begin
				pend_we = 1'b1;
				cnt_d   = heu_pkg::CW'(cnt_q + 3'd1);
			end
			if (eos_q) begin
				rd_d    = '0;
				fin_d   = 1'b1;
				state_d = heu_pkg::S_RELEASE;
			end else begin
				state_d = heu_pkg::S_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= heu_pkg::S_IDLE;
			cnt_q   <= '0;
			cand_q  <= '0;
			k_q     <= '0;
			rd_q    <= '0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			cand_q  <= cand_d;
			k_q     <= k_d;
			rd_q    <= rd_d;
			fin_q   <= fin_d;
		end
	end

	always_ff @(posedge clk) begin
		emit_q <= emit_d;
		if (acc) begin
			byte_q <= item.text_byte;
			eos_q  <= item.end_of_string;
		end
		if (pend_we)
			pend_q[cnt_q] <= byte_q;
	end

endmodule

// ===== src/html_entity_unescape.sv =====
// Flow: a new request is accepted only while the sequencer is idle; a plain byte is held in
// byte_q, evaluated in S_EVAL and then registered into the output, and the second byte of a
// candidate is compared in S_SCAN while the compare unit walks the table one entry at a time;
// a mismatch releases the held bytes one by one and then handles the new byte afresh.
// Output back-pressure stalls the sequencer.
// Reset: arst_n clears the sequencer, hold count and output valid asynchronously.
// ----------------------------------------------------------------------------
// html_entity_unescape
// Streaming decoder for &amp; &lt; &gt; &quot; and &#39; with registered output.
// ----------------------------------------------------------------------------
module html_entity_unescape (
	input  logic          clk,
	input  logic          arst_n,
	heu_in_if.sink        text_in,
	heu_out_if.source     text_out
);

	logic              acc;
	logic              idle;
	logic              take;
	heu_pkg::in_item_t item;
	heu_pkg::emit_t    emit;

	logic              out_vld_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;

	assign text_in.ready = idle;
	assign acc           = text_in.valid && idle;
	assign item.text_byte     = text_in.text_byte;
	assign item.end_of_string = text_in.end_of_string;

	// output register frees when empty or drained this cycle
	assign take = !out_vld_q || text_out.ready;

	heu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.item   (item),
		.idle   (idle),
		.take   (take),
		.emit   (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (take) begin
			out_vld_q <= emit.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit.vld) begin
			out_byte_q <= emit.data;
			out_last_q <= emit.last;
		end
	end

	assign text_out.valid    = out_vld_q;
	assign text_out.out_byte = out_byte_q;
	assign text_out.out_last = out_last_q;

endmodule

// ===== src/heu_checker.sv =====
// ----------------------------------------------------------------------------
// heu_checker
// Port-level checks on the entity decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module heu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last
);

	// after an accepted request, ready drops while the sequencer evaluates the byte
	`HEU_ASSERT_NXT(a_busy_after_req, clk, arst_n, in_valid && in_ready, !in_ready)

	// a presented byte carries known data
	`HEU_ASSERT_IMP(a_out_known, clk, arst_n, out_valid,
		!$isunknown(out_byte) && !$isunknown(out_last))

	`HEU_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_byte) && $stable(out_last))

endmodule

bind html_entity_unescape heu_checker u_heu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (text_in.valid),
	.in_ready  (text_in.ready),
	.out_valid (text_out.valid),
	.out_ready (text_out.ready),
	.out_byte  (text_out.out_byte),
	.out_last  (text_out.out_last)
);

// ===== tb/heu_decode_checker.sv =====
// ----------------------------------------------------------------------------
// heu_decode_checker
// Watches both text channels, decodes each accepted request into the bytes
// the decoder should produce and compares them in order with its output.
// ----------------------------------------------------------------------------
module heu_decode_checker (
	input  logic clk,
	input  logic arst_n,
	heu_in_if    text_in,
	heu_out_if   text_out,
	output int   results_waiting,
	output int   mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_ENT   = (heu_pkg::ENTITY_COUNT > 5) ? 5 : heu_pkg::ENTITY_COUNT;
	localparam int HOLD_MAX  = 5;
	localparam int PRINT_CAP = 100;

	// entity text packed right-aligned: first character in the highest used byte
	localparam logic [47:0] ENT_STR [5] = '{"&amp;", "&lt;", "&gt;", "&quot;", "&#39;"};
	localparam int          ENT_N   [5] = '{5, 4, 4, 6, 5};
	localparam logic [7:0]  ENT_OUT [5] = '{"&", "<", ">", "\"", "'"};

	typedef struct packed {
		logic [7:0] chr;
		logic       last;
	} dec_byte_t;

	dec_byte_t   decoded_q [$];
	logic [7:0]  held [HOLD_MAX];
	int unsigned held_n;
	int unsigned cand;
	int          err_cnt;

	function automatic logic [7:0] ent_char_at(input int k, input int i);
		return ENT_STR[k][(ENT_N[k] - 1 - i) * 8 +: 8];
	endfunction

	task automatic report_mismatch(input string msg);
		if (err_cnt < PRINT_CAP)
			$display("[%0t] MISMATCH: %s", $time, msg);
		err_cnt++;
	endtask

	task automatic hold_byte(input logic [7:0] b);
		if (held_n < HOLD_MAX) begin
			held[held_n] = b;
			held_n++;
		end
	endtask

	task automatic release_held();
		for (int i = 0; i < held_n; i++)
			decoded_q.push_back('{chr: held[i], last: 1'b0});
		held_n = 0;
		cand   = 0;
	endtask

	task automatic start_or_pass(input logic [7:0] b);
		if (b == "&")
			hold_byte(b);
		else
			decoded_q.push_back('{chr: b, last: 1'b0});
	endtask

	// Work out the decoded bytes caused by one input request.
	task automatic decode_text_byte(input logic [7:0] b, input logic eos);
		logic [7:0] lb;
		int         base;
		bit         taken;
		base  = decoded_q.size();
		lb    = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
		taken = 0;
		if (held_n == 0) begin
			start_or_pass(b);
			taken = 1;
		end else if (held_n == 1) begin
			for (int k = 0; k < NUM_ENT && !taken; k++) begin
				if (ent_char_at(k, 1) == lb) begin
					cand = k;
					hold_byte(b);
					taken = 1;
				end
			end
		end else if (cand < NUM_ENT && held_n < ENT_N[cand] &&
				ent_char_at(cand, held_n) == lb) begin
			if (held_n + 1 == ENT_N[cand]) begin
				decoded_q.push_back('{chr: ENT_OUT[cand], last: 1'b0});
				held_n = 0;
				cand   = 0;
			end else begin
				hold_byte(b);
			end
			taken = 1;
		end
		// mismatch: release what was held, then treat the byte afresh
		if (!taken) begin
			release_held();
			start_or_pass(b);
		end
		if (eos) begin
			release_held();
			if (decoded_q.size() > base)
				decoded_q[decoded_q.size() - 1].last = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		dec_byte_t want;
		if (!arst_n) begin
			decoded_q.delete();
			held_n = 0;
			cand   = 0;
			err_cnt = 0;
			results_waiting <= 0;
			mismatches      <= 0;
		end else begin
			if (text_out.valid && text_out.ready) begin
				if (decoded_q.size() == 0) begin
					report_mismatch($sformatf("unexpected output byte 0x%02h last %0b",
						text_out.out_byte, text_out.out_last));
				end else begin
					want = decoded_q.pop_front();
					if (text_out.out_byte !== want.chr)
						report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
							text_out.out_byte, want.chr));
					if (text_out.out_last !== want.last)
						report_mismatch($sformatf("out_last %0b on byte 0x%02h, expected %0b",
							text_out.out_last, want.chr, want.last));
				end
			end
			if (text_in.valid && text_in.ready)
				decode_text_byte(text_in.text_byte, text_in.end_of_string);
			results_waiting <= decoded_q.size();
			mismatches      <= err_cnt;
		end
	end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives escaped strings into the entity decoder: a directed set of every
// entity in mixed case, a flush mid-entity and extreme bytes, then random
// strings of entities, broken entities and plain bytes, under random idling
// and back-pressure. The checker beside the block gives the failure count.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES  = 200;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS  = 32;
	localparam int NUM_PHASES   = 8;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PATTERN
	} rx_mode_t;

	logic clk;
	logic arst_n;

	heu_in_if  text_in();
	heu_out_if text_out();

	int results_waiting;
	int mismatches;

	html_entity_unescape DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_in  (text_in),
		.text_out (text_out)
	);

	heu_decode_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.text_in         (text_in),
		.text_out        (text_out),
		.results_waiting (results_waiting),
		.mismatches      (mismatches)
	);

	logic [7:0] phrase [$];
	int         items_sent;
	int         burst_left;
	int         burst_max;
	int         gap_max;
	rx_mode_t   rx_mode;
	logic [7:0] rx_pattern;
	bit         hold_request;
	int         idle_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: own stall pattern, plus one long hold-off on request
	initial begin
		int idx;
		idx = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 0;
				text_out.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				case (rx_mode)
					RX_ALWAYS: text_out.ready <= 1'b1;
					RX_RANDOM: text_out.ready <= ($urandom_range(0, 99) < 65);
					default:   text_out.ready <= rx_pattern[idx % 8];
				endcase
				idx++;
			end
		end
	end

	always @(posedge clk) begin
		if ((text_in.valid && text_in.ready) || (text_out.valid && text_out.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [7:0] mix_case(input logic [7:0] c);
		if (c >= "a" && c <= "z" && $urandom_range(0, 1))
			return c - 8'd32;
		return c;
	endfunction

	task automatic append_text(input string s);
		for (int i = 0; i < s.len(); i++)
			phrase.push_back(s[i]);
	endtask

	// Offer one request, with a random gap at the start of each burst.
	task automatic send_byte(input logic [7:0] b, input logic eos);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, burst_max);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				text_in.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		text_in.valid         <= 1'b1;
		text_in.text_byte     <= b;
		text_in.end_of_string <= eos;
		@(posedge clk);
		while (!text_in.ready) @(posedge clk);
		@(negedge clk);
		burst_left--;
		items_sent++;
	endtask

	task automatic send_phrase();
		for (int i = 0; i < phrase.size(); i++)
			send_byte(phrase[i], i == phrase.size() - 1);
		phrase.delete();
	endtask

	// Hold the sender until every expected byte has come out.
	task automatic drain_results();
		text_in.valid <= 1'b0;
		burst_left = 0;
		while (results_waiting != 0) @(negedge clk);
	endtask

	// Mostly well-formed entities in random case, with broken entities and noise.
	task automatic build_phrase();
		int segs;
		int r;
		int k;
		int cut;
		segs = $urandom_range(1, 4);
		for (int s = 0; s < segs; s++) begin
			r = $urandom_range(0, 99);
			k = $urandom_range(0, 4);
			if (r < 55) begin
				for (int i = 0; i < int'(heu_pkg::ENT_LEN[k]); i++)
					phrase.push_back(mix_case(heu_pkg::ENT_TEXT[k][i]));
			end else if (r < 80) begin
				cut = $urandom_range(1, int'(heu_pkg::ENT_LEN[k]) - 1);
				for (int i = 0; i < cut; i++)
					phrase.push_back(mix_case(heu_pkg::ENT_TEXT[k][i]));
				case ($urandom_range(0, 2))
					0: phrase.push_back("&");
					1: phrase.push_back(8'($urandom_range(1, 255)));
					default: ; // let the string end mid-entity when it is the last segment
				endcase
			end else begin
				repeat ($urandom_range(1, 3))
					phrase.push_back(($urandom_range(0, 4) == 0) ? 8'h26 :
						8'($urandom_range(1, 255)));
			end
		end
	endtask

	initial begin
		int target;
		arst_n                = 1'b0;
		text_in.valid         = 1'b0;
		text_in.text_byte     = 8'h00;
		text_in.end_of_string = 1'b0;
		text_out.ready        = 1'b0;
		rx_mode      = RX_ALWAYS;
		rx_pattern   = 8'hFF;
		hold_request = 0;
		items_sent   = 0;
		burst_left   = 0;
		burst_max    = 64;
		gap_max      = 0;
		idle_cycles  = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// every entity in mixed case, a flush mid-entity, then extreme bytes
		append_text("&amp;&lT;&Gt;&QuOt;&#39;");
		send_phrase();
		append_text("&quo");
		send_phrase();
		phrase.push_back(8'hFF);
		send_phrase();
		phrase.push_back(8'h01);
		phrase.push_back(8'h7F);
		send_phrase();
		drain_results();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			gap_max    = (ph % 3 == 0) ? 0 : $urandom_range(2, 10);
			burst_max  = $urandom_range(1, 16);
			burst_left = 0;
			rx_mode    = rx_mode_t'(ph % 3);
			rx_pattern = 8'($urandom_range(1, 255));
			if (ph == 2)
				hold_request = 1;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				build_phrase();
				send_phrase();
			end
			if (ph == 2 || $urandom_range(0, 1))
				drain_results();
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
